/* rtl/uvs_pkg.sv */
// Shared types and constants for the UV sphere vertex generator.
`timescale 1ns / 1ps

package uvs_pkg;

    localparam int CNT_W    = 9;    // count registers and grid indexes
    localparam int QUO_W    = 17;   // quotient bits of the phase/texture dividers
    localparam int OFF_W    = 15;   // quarter-wave offset, 0..16384
    localparam int K_W      = 31;   // Q30 sine magnitude, up to 1.0
    localparam int SINE_LAT = 10;   // register stages in the sine kernel

    localparam logic [K_W-1:0] Q30_ONE    = 31'h4000_0000;
    localparam logic [32:0]    TWO_PI_Q30 = 33'd6746518852;

    typedef enum logic [1:0]
    {
        REG_RADIUS  = 2'd0,
        REG_SECTORS = 2'd1,
        REG_STACKS  = 2'd2
    } cfg_reg_t;

    // quarter-wave lookup: sign of the result and kernel offset
    typedef struct packed
    {
        logic             neg;
        logic [OFF_W-1:0] q;
    } phase_t;

    // side data that rides along with the sine kernel
    typedef struct packed
    {
        logic             err;
        logic [QUO_W-1:0] u;
        logic [QUO_W-1:0] v;
        logic             neg_sx;
        logic             neg_cz;
        logic             neg_ax;
        logic             neg_ay;
    } meta_t;

endpackage

/* rtl/uvs_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps

module uvs_div #(
    parameter int VW = 9,
    parameter int QW = 17
) (
    input  logic             clk,
    input  logic             en,
    input  logic [VW+QW-1:0] dividend,
    input  logic [VW-1:0]    divisor,
    output logic [QW-1:0]    quotient
);

    // the user must hold the divisor steady while words are in flight; the divider does not enforce it
    for (genvar k = 0; k < QW; k++)
    begin : g_step
        logic [VW-1:0] rem_in;
        logic [QW-1:0] low_in;
        logic [QW-1:0] quo_in;
        logic [VW:0]   trial;
        logic          geq;
        logic [VW-1:0] rem_reg;
        logic [QW-1:0] low_reg;
        logic [QW-1:0] quo_reg;

        if (k == 0)
        begin : g_first
            assign rem_in = dividend[VW+QW-1:QW];
            assign low_in = dividend[QW-1:0];
            assign quo_in = '0;
        end
        else
        begin : g_next
            assign rem_in = g_step[k-1].rem_reg;
            assign low_in = g_step[k-1].low_reg;
            assign quo_in = g_step[k-1].quo_reg;
        end

        assign trial = {rem_in, low_in[QW-1]};
        assign geq   = trial >= {1'b0, divisor};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg <= geq ? VW'(trial - {1'b0, divisor}) : trial[VW-1:0];
                low_reg <= {low_in[QW-2:0], 1'b0};
                quo_reg <= {quo_in[QW-2:0], geq};
            end
        end
    end

    assign quotient = g_step[QW-1].quo_reg;

endmodule

/* rtl/uvs_sine.sv */
// Pipelined quarter-wave sine kernel, Q30 Taylor series.
`timescale 1ns / 1ps

module uvs_sine (
    input  logic                     clk,
    input  logic                     en,
    input  logic [uvs_pkg::OFF_W-1:0] q,
    output logic [uvs_pkg::K_W-1:0]   k
);

    // reciprocals for exact floor division by 9, 21, 5 and 3
    localparam logic [31:0] M9  = 32'(((64'd1 << 33) + 64'd8) / 64'd9);
    localparam logic [31:0] M21 = 32'(((64'd1 << 36) + 64'd20) / 64'd21);
    localparam logic [31:0] M5  = 32'(((64'd1 << 33) + 64'd4) / 64'd5);
    localparam logic [31:0] M3  = 32'(((64'd1 << 33) + 64'd2) / 64'd3);

    logic [30:0] x_reg  [9];
    logic [31:0] sq_reg [6];
    logic [30:0] t1_reg, t2_reg, t3_reg, t4_reg, k_reg;
    logic [31:0] y1_reg, y2_reg, y3_reg;

    logic [47:0] x_prod;
    logic [61:0] sq_prod;
    logic [63:0] d1_prod, d2_prod, d3_prod, d4_prod;
    logic [62:0] y1_prod, y2_prod, y3_prod;
    logic [61:0] k_prod;
    logic [31:0] k_full;

    assign x_prod  = 48'(q) * 48'(uvs_pkg::TWO_PI_Q30);
    assign sq_prod = 62'(x_reg[0]) * 62'(x_reg[0]);
    assign d1_prod = 64'(sq_reg[0][31:3]) * 64'(M9);      // x2 / 72
    assign y1_prod = 63'(sq_reg[1]) * 63'(t1_reg);
    assign d2_prod = 64'(y1_reg[31:1]) * 64'(M21);        // / 42
    assign y2_prod = 63'(sq_reg[3]) * 63'(t2_reg);
    assign d3_prod = 64'(y2_reg[31:2]) * 64'(M5);         // / 20
    assign y3_prod = 63'(sq_reg[5]) * 63'(t3_reg);
    assign d4_prod = 64'(y3_reg[31:1]) * 64'(M3);         // / 6
    assign k_prod  = 62'(x_reg[8]) * 62'(t4_reg);
    assign k_full  = 32'(k_prod >> 30);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= 31'(x_prod >> 16);
            for (int s = 1; s < 9; s++)
            begin
                x_reg[s] <= x_reg[s-1];
            end
            sq_reg[0] <= 32'(sq_prod >> 30);
            for (int s = 1; s < 6; s++)
            begin
                sq_reg[s] <= sq_reg[s-1];
            end
            t1_reg <= uvs_pkg::Q30_ONE - 31'(d1_prod >> 33);
            y1_reg <= 32'(y1_prod >> 30);
            t2_reg <= uvs_pkg::Q30_ONE - 31'(d2_prod >> 36);
            y2_reg <= 32'(y2_prod >> 30);
            t3_reg <= uvs_pkg::Q30_ONE - 31'(d3_prod >> 33);
            y3_reg <= 32'(y3_prod >> 30);
            t4_reg <= uvs_pkg::Q30_ONE - 31'(d4_prod >> 33);
            k_reg  <= (k_full > 32'(uvs_pkg::Q30_ONE)) ? uvs_pkg::Q30_ONE : k_full[30:0];
        end
    end

    assign k = k_reg;

endmodule

/* rtl/uv_sphere_vertex_generator_unit.sv */
// Top level of the UV sphere vertex generator.
`timescale 1ns / 1ps

// Takes one (stack, sector) grid index word per clock and returns one vertex word per
// clock while the output is not stalled: position in signed Q8.8 and texture coordinate
// in Q1.16. The pipeline is 32 register stages deep. The stages are the range check,
// the 17-stage quotient pipeline that forms the angle phases and texture coordinates,
// the quadrant fold, the 10-stage sine kernel, and three stages of radius scaling and
// saturation. A stall on the output freezes the whole pipeline; words are never dropped.
// Configuration writes take effect at once and belong in idle periods.

module uv_sphere_vertex_generator_unit #(
    parameter int MAX_DIVISIONS = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [8:0]         stack_index,
    input  logic [8:0]         sector_index,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] x_pos,
    output logic signed [15:0] y_pos,
    output logic signed [15:0] z_pos,
    output logic [16:0]        u_coord,
    output logic [16:0]        v_coord,
    output logic               index_error
);

    localparam int DIV_LAT   = uvs_pkg::QUO_W;
    localparam int STG_PHASE = DIV_LAT + 1;
    localparam int STG_LAST  = STG_PHASE + uvs_pkg::SINE_LAT + 3;
    localparam int DVD_W     = uvs_pkg::CNT_W + uvs_pkg::QUO_W;

    function automatic uvs_pkg::phase_t phase_sine(input logic [15:0] p);
        uvs_pkg::phase_t r;
        r.neg = p[15];
        r.q   = p[14] ? 15'(15'd16384 - {1'b0, p[13:0]}) : {1'b0, p[13:0]};
        return r;
    endfunction

    function automatic logic [15:0] sat16(input logic neg, input logic [16:0] mag);
        logic [15:0] r;
        if (neg)
        begin
            r = (mag > 17'd32768) ? 16'h8000 : 16'(17'd0 - mag);
        end
        else
        begin
            r = (mag > 17'd32767) ? 16'h7FFF : mag[15:0];
        end
        return r;
    endfunction

    // configuration
    logic [15:0] radius_reg;
    logic [8:0]  sectors_reg, stacks_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg  <= 16'd256;
            sectors_reg <= 9'd36;
            stacks_reg  <= 9'd18;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                uvs_pkg::REG_RADIUS:  radius_reg  <= cfg_data;
                uvs_pkg::REG_SECTORS: sectors_reg <= cfg_data[8:0];
                uvs_pkg::REG_STACKS:  stacks_reg  <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    logic [8:0] ns, nt;
    assign ns = (32'(sectors_reg) > MAX_DIVISIONS) ? 9'(MAX_DIVISIONS) : sectors_reg;
    assign nt = (32'(stacks_reg)  > MAX_DIVISIONS) ? 9'(MAX_DIVISIONS) : stacks_reg;

    // pipeline control: the output register stalls everything behind it
    logic [STG_LAST:0] vld_reg;
    logic              en;

    assign en        = !(vld_reg[STG_LAST] && out_stall);
    assign in_stall  = vld_reg[STG_LAST] && out_stall;
    assign out_valid = vld_reg[STG_LAST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[STG_LAST-1:0], in_valid};
        end
    end

    // stage 0: range check and dividends
    logic             err_reg [DIV_LAT+1];
    logic [DVD_W-1:0] du_reg, dv_reg, dp_reg;
    logic             err_in;

    assign err_in = (ns == 9'd0) || (nt == 9'd0) || (stack_index > nt) || (sector_index > ns);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            err_reg[0] <= err_in;
            for (int s = 1; s <= DIV_LAT; s++)
            begin
                err_reg[s] <= err_reg[s-1];
            end
            du_reg <= (DVD_W'(sector_index) << 16) + DVD_W'(ns >> 1);
            dv_reg <= (DVD_W'(stack_index) << 16) + DVD_W'(nt >> 1);
            dp_reg <= (DVD_W'(stack_index) << 15) + DVD_W'(nt >> 1);
        end
    end

    logic [uvs_pkg::QUO_W-1:0] u_q, v_q, p_q;

    uvs_div #(.VW(uvs_pkg::CNT_W), .QW(uvs_pkg::QUO_W)) u_div_u (
        .clk(clk), .en(en), .dividend(du_reg), .divisor(ns), .quotient(u_q)
    );
    uvs_div #(.VW(uvs_pkg::CNT_W), .QW(uvs_pkg::QUO_W)) u_div_v (
        .clk(clk), .en(en), .dividend(dv_reg), .divisor(nt), .quotient(v_q)
    );
    uvs_div #(.VW(uvs_pkg::CNT_W), .QW(uvs_pkg::QUO_W)) u_div_p (
        .clk(clk), .en(en), .dividend(dp_reg), .divisor(nt), .quotient(p_q)
    );

    // phase stage: quadrant folding, cos(p) = sin(p + quarter turn)
    uvs_pkg::phase_t ph_sx, ph_cz, ph_ax, ph_ay;
    assign ph_sx = phase_sine(p_q[15:0]);
    assign ph_cz = phase_sine(p_q[15:0] + 16'd16384);
    assign ph_ax = phase_sine(u_q[15:0] + 16'd16384);
    assign ph_ay = phase_sine(u_q[15:0]);

    logic [uvs_pkg::OFF_W-1:0] q_sx_reg, q_cz_reg, q_ax_reg, q_ay_reg;
    uvs_pkg::meta_t            meta_reg [uvs_pkg::SINE_LAT+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_sx_reg <= ph_sx.q;
            q_cz_reg <= ph_cz.q;
            q_ax_reg <= ph_ax.q;
            q_ay_reg <= ph_ay.q;
            meta_reg[0] <= '{err: err_reg[DIV_LAT], u: u_q, v: v_q, neg_sx: ph_sx.neg,
                             neg_cz: ph_cz.neg, neg_ax: ph_ax.neg, neg_ay: ph_ay.neg};
            for (int s = 1; s <= uvs_pkg::SINE_LAT; s++)
            begin
                meta_reg[s] <= meta_reg[s-1];
            end
        end
    end

    logic [uvs_pkg::K_W-1:0] k_sx, k_cz, k_ax, k_ay;

    uvs_sine u_sine_sx (.clk(clk), .en(en), .q(q_sx_reg), .k(k_sx));
    uvs_sine u_sine_cz (.clk(clk), .en(en), .q(q_cz_reg), .k(k_cz));
    uvs_sine u_sine_ax (.clk(clk), .en(en), .q(q_ax_reg), .k(k_ax));
    uvs_sine u_sine_ay (.clk(clk), .en(en), .q(q_ay_reg), .k(k_ay));

    // scale stage 1: z magnitude and the sin(stack) radius term
    uvs_pkg::meta_t          m1_reg, m2_reg;
    logic [16:0]             zmag1_reg, zmag2_reg;
    logic [31:0]             m_reg;
    logic [uvs_pkg::K_W-1:0] ax_reg, ay_reg;
    logic [16:0]             xmag_reg, ymag_reg;
    uvs_pkg::meta_t          mk;
    uvs_pkg::meta_t          mk_fix;
    logic [47:0]             z_prod, m_prod;
    logic [63:0]             x_prod, y_prod;

    assign mk     = meta_reg[uvs_pkg::SINE_LAT];
    assign z_prod = 48'(radius_reg) * 48'(k_cz) + (48'd1 << 29);
    assign m_prod = 48'(radius_reg) * 48'(k_sx);
    assign x_prod = 64'(m_reg) * 64'(ax_reg) + (64'd1 << 45);
    assign y_prod = 64'(m_reg) * 64'(ay_reg) + (64'd1 << 45);

    // a zero magnitude carries no sign
    always_comb
    begin
        mk_fix        = mk;
        mk_fix.neg_cz = mk.neg_cz && (k_cz != '0);
        mk_fix.neg_ax = mk.neg_ax && (k_ax != '0);
        mk_fix.neg_ay = mk.neg_ay && (k_ay != '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_reg        <= mk_fix;
            zmag1_reg     <= 17'(z_prod >> 30);
            m_reg         <= (mk.neg_sx && (k_sx != '0)) ? 32'd0 : 32'(m_prod >> 14);
            ax_reg        <= k_ax;
            ay_reg        <= k_ay;

            m2_reg    <= m1_reg;
            zmag2_reg <= zmag1_reg;
            xmag_reg  <= 17'(x_prod >> 46);
            ymag_reg  <= 17'(y_prod >> 46);
        end
    end

    // output register
    logic [15:0] x_reg, y_reg, z_reg;
    logic [16:0] u_reg, v_reg;
    logic        err_out_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            err_out_reg <= m2_reg.err;
            if (m2_reg.err)
            begin
                x_reg <= '0;
                y_reg <= '0;
                z_reg <= '0;
                u_reg <= '0;
                v_reg <= '0;
            end
            else
            begin
                x_reg <= sat16(m2_reg.neg_ax && (xmag_reg != '0), xmag_reg);
                y_reg <= sat16(m2_reg.neg_ay && (ymag_reg != '0), ymag_reg);
                z_reg <= sat16(m2_reg.neg_cz && (zmag2_reg != '0), zmag2_reg);
                u_reg <= m2_reg.u;
                v_reg <= m2_reg.v;
            end
        end
    end

    assign x_pos       = x_reg;
    assign y_pos       = y_reg;
    assign z_pos       = z_reg;
    assign u_coord     = u_reg;
    assign v_coord     = v_reg;
    assign index_error = err_out_reg;

`ifndef NO_ASSERTIONS
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && index_error |-> x_pos == 0 && y_pos == 0 && z_pos == 0
            && u_coord == 0 && v_coord == 0)
        else $error("rejected word carries nonzero fields");

    a_tex_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !index_error |-> u_coord <= 17'd65536 && v_coord <= 17'd65536)
        else $error("texture coordinate above one");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !index_error && radius_reg < 16'd32767
            |-> x_pos <= $signed({1'b0, radius_reg}) && x_pos >= -$signed({1'b0, radius_reg})
             && y_pos <= $signed({1'b0, radius_reg}) && y_pos >= -$signed({1'b0, radius_reg}))
        else $error("position outside the sphere radius");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(x_pos) && $stable(u_coord))
        else $error("stalled word changed");
`endif

endmodule

/* verif/tb.sv */
// Testbench for the UV sphere vertex generator: directed table, then random words.
`timescale 1ns / 1ps

module tb;

    typedef struct packed
    {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic [16:0] u;
        logic [16:0] v;
        logic        err;
    } vertex_t;

    typedef struct packed
    {
        logic [8:0] i;
        logic [8:0] j;
        logic       typed;
        vertex_t    want;
    } grid_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    uvs_pkg::cfg_reg_t  cfg_index = uvs_pkg::REG_RADIUS;
    logic [15:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [8:0]         stack_index = '0;
    logic [8:0]         sector_index = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
    logic signed [15:0] z_pos;
    logic [16:0]        u_coord;
    logic [16:0]        v_coord;
    logic               index_error;

    vertex_t     pending_vertices[$];
    int          fail_count = 0;
    int          cycle_count = 0;
    bit          quiet = 1'b0;
    bit          hold_req = 1'b0;
    logic [15:0] radius_m = 16'd256;
    logic [8:0]  sectors_m = 9'd36;
    logic [8:0]  stacks_m = 9'd18;

    uv_sphere_vertex_generator_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .stack_index(stack_index), .sector_index(sector_index),
        .out_valid(out_valid), .out_stall(out_stall),
        .x_pos(x_pos), .y_pos(y_pos), .z_pos(z_pos),
        .u_coord(u_coord), .v_coord(v_coord), .index_error(index_error)
    );

    always #5 clk = ~clk;

    // sine of q/65536 turn, q in 0..16384, Q30
    function automatic logic [63:0] quarter_wave(input logic [63:0] q);
        logic [63:0] x, x2, t, s;
        x  = (q * 64'd6746518852) >> 16;
        x2 = (x * x) >> 30;
        t  = (64'd1 << 30) - x2 / 64'd72;
        t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd42;
        t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd20;
        t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        return (s > (64'd1 << 30)) ? (64'd1 << 30) : s;
    endfunction

    function automatic logic [63:0] turn_sine(input logic [15:0] p, output bit neg);
        logic [63:0] mag;
        mag = p[14] ? quarter_wave(64'd16384 - 64'(p[13:0])) : quarter_wave(64'(p[13:0]));
        neg = p[15] && (mag != 0);
        return mag;
    endfunction

    function automatic logic [15:0] clamp_q88(input bit neg, input logic [63:0] mag);
        if (neg)
            return (mag > 64'd32768) ? 16'h8000 : 16'(-mag);
        return (mag > 64'd32767) ? 16'h7FFF : mag[15:0];
    endfunction

    function automatic vertex_t vertex_of(input logic [8:0] i_in, input logic [8:0] j_in);
        vertex_t     vo;
        logic [63:0] i, j, ns, nt, r, u, v, sx, cz, m, ax, ay, zm, xm, ym;
        logic [15:0] ps, pt;
        bit          nsx, nz, nx, ny;
        i  = 64'(i_in);
        j  = 64'(j_in);
        ns = (sectors_m > 9'd256) ? 64'd256 : 64'(sectors_m);
        nt = (stacks_m > 9'd256) ? 64'd256 : 64'(stacks_m);
        r  = 64'(radius_m);
        vo = '0;
        if (ns == 0 || nt == 0 || i > nt || j > ns)
        begin
            vo.err = 1'b1;
            return vo;
        end
        u  = (j * 64'd65536 + ns / 2) / ns;
        v  = (i * 64'd65536 + nt / 2) / nt;
        ps = u[15:0];
        pt = 16'((i * 64'd32768 + nt / 2) / nt);
        sx = turn_sine(pt, nsx);
        cz = turn_sine(pt + 16'd16384, nz);
        zm = (r * cz + (64'd1 << 29)) >> 30;
        m  = nsx ? 64'd0 : (r * sx) >> 14;
        ax = turn_sine(ps + 16'd16384, nx);
        ay = turn_sine(ps, ny);
        xm = (m * ax + (64'd1 << 45)) >> 46;
        ym = (m * ay + (64'd1 << 45)) >> 46;
        vo.x = clamp_q88(nx && xm != 0, xm);
        vo.y = clamp_q88(ny && ym != 0, ym);
        vo.z = clamp_q88(nz && zm != 0, zm);
        vo.u = u[16:0];
        vo.v = v[16:0];
        return vo;
    endfunction

    task automatic write_reg(input uvs_pkg::cfg_reg_t idx, input logic [15:0] d);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = d;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        case (idx)
            uvs_pkg::REG_RADIUS:  radius_m = d;
            uvs_pkg::REG_SECTORS: sectors_m = d[8:0];
            uvs_pkg::REG_STACKS:  stacks_m = d[8:0];
            default: ;
        endcase
    endtask

    // called at a falling edge; returns at the falling edge after the word is taken
    task automatic send_word(input logic [8:0] i, input logic [8:0] j,
                             input bit typed, input vertex_t want);
        while (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        in_valid     = 1'b1;
        stack_index  = i;
        sector_index = j;
        do
            @(posedge clk);
        while (in_stall);
        pending_vertices.insert(pending_vertices.size(), typed ? want : vertex_of(i, j));
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid = 1'b0;
        @(negedge clk);
        while (pending_vertices.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic random_words(input int n);
        logic [8:0] nt, ns, i, j;
        nt = (stacks_m > 9'd256) ? 9'd256 : stacks_m;
        ns = (sectors_m > 9'd256) ? 9'd256 : sectors_m;
        repeat (n)
        begin
            case ($urandom_range(0, 9))
                8:
                begin
                    i = 9'(nt + $urandom_range(0, 2));
                    j = 9'(ns + $urandom_range(0, 2));
                end
                9:
                begin
                    i = 9'($urandom);
                    j = 9'($urandom);
                end
                default:
                begin
                    i = 9'($urandom_range(0, nt));
                    j = 9'($urandom_range(0, ns));
                end
            endcase
            send_word(i, j, 1'b0, '0);
        end
    endtask

    // reset setting: 36 sectors, 18 stacks, radius 1.0
    grid_row_t grid_table[15] = '{
        '{9'd0,   9'd0,   1'b1, '{16'd0, 16'd0, 16'd256,   17'd0, 17'd0,     1'b0}},
        '{9'd18,  9'd0,   1'b1, '{16'd0, 16'd0, 16'hFF00,  17'd0, 17'd65536, 1'b0}},
        '{9'd19,  9'd0,   1'b1, '{16'd0, 16'd0, 16'd0,     17'd0, 17'd0,     1'b1}},
        '{9'd0,   9'd37,  1'b1, '{16'd0, 16'd0, 16'd0,     17'd0, 17'd0,     1'b1}},
        '{9'd511, 9'd511, 1'b1, '{16'd0, 16'd0, 16'd0,     17'd0, 17'd0,     1'b1}},
        '{9'd256, 9'd0,   1'b1, '{16'd0, 16'd0, 16'd0,     17'd0, 17'd0,     1'b1}},
        '{9'd0,   9'd256, 1'b1, '{16'd0, 16'd0, 16'd0,     17'd0, 17'd0,     1'b1}},
        '{9'd9,   9'd36,  1'b0, '0},
        '{9'd9,   9'd0,   1'b0, '0},
        '{9'd9,   9'd9,   1'b0, '0},
        '{9'd9,   9'd18,  1'b0, '0},
        '{9'd9,   9'd27,  1'b0, '0},
        '{9'd1,   9'd1,   1'b0, '0},
        '{9'd17,  9'd35,  1'b0, '0},
        '{9'd18,  9'd36,  1'b0, '0}
    };

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        foreach (grid_table[k])
            send_word(grid_table[k].i, grid_table[k].j, grid_table[k].typed,
                      grid_table[k].want);
        random_words(150);
        drain();

        // small grid of 3 sectors and 2 stacks, zero radius
        write_reg(uvs_pkg::REG_RADIUS, 16'd0);
        write_reg(uvs_pkg::REG_SECTORS, 16'd3);
        write_reg(uvs_pkg::REG_STACKS, 16'd2);
        random_words(100);
        drain();

        // largest grid, largest radius; receiver holds off to back up the pipe
        write_reg(uvs_pkg::REG_RADIUS, 16'hFFFF);
        write_reg(uvs_pkg::REG_SECTORS, 16'd256);
        write_reg(uvs_pkg::REG_STACKS, 16'd256);
        hold_req = 1'b1;
        random_words(250);
        drain();

        // counts above the clamp, degenerate counts
        write_reg(uvs_pkg::REG_SECTORS, 16'hFFFF);
        write_reg(uvs_pkg::REG_STACKS, 16'd1);
        write_reg(uvs_pkg::REG_RADIUS, 16'h1234);
        random_words(120);
        drain();
        write_reg(uvs_pkg::REG_SECTORS, 16'd1);
        write_reg(uvs_pkg::REG_STACKS, 16'd300);
        random_words(80);
        drain();
        write_reg(uvs_pkg::REG_SECTORS, 16'd2);
        random_words(60);
        drain();

        // zero count rejects everything
        write_reg(uvs_pkg::REG_SECTORS, 16'd0);
        random_words(40);
        drain();
        write_reg(uvs_pkg::REG_SECTORS, 16'd40);
        write_reg(uvs_pkg::REG_STACKS, 16'd0);
        random_words(40);
        drain();

        repeat (6)
        begin
            write_reg(uvs_pkg::REG_RADIUS, 16'($urandom));
            write_reg(uvs_pkg::REG_SECTORS, 16'($urandom_range(3, 256)));
            write_reg(uvs_pkg::REG_STACKS, 16'($urandom_range(2, 256)));
            random_words(150);
            drain();
        end

        quiet = 1'b1;
        write_reg(uvs_pkg::REG_RADIUS, 16'd256);
        write_reg(uvs_pkg::REG_SECTORS, 16'd36);
        write_reg(uvs_pkg::REG_STACKS, 16'd18);
        random_words(150);
        drain();

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // receiver: short random stalls, one long hold-off on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                out_stall = 1'b1;
                repeat (300) @(negedge clk);
                out_stall = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 3)) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        vertex_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_vertices.size() == 0)
            begin
                $error("vertex word with nothing pending");
                fail_count++;
            end
            else
            begin
                w = pending_vertices.pop_front();
                if (x_pos !== w.x)
                begin
                    $error("x_pos: expected %0d, got %0d", $signed(w.x), x_pos);
                    fail_count++;
                end
                if (y_pos !== w.y)
                begin
                    $error("y_pos: expected %0d, got %0d", $signed(w.y), y_pos);
                    fail_count++;
                end
                if (z_pos !== w.z)
                begin
                    $error("z_pos: expected %0d, got %0d", $signed(w.z), z_pos);
                    fail_count++;
                end
                if (u_coord !== w.u)
                begin
                    $error("u_coord: expected %0d, got %0d", w.u, u_coord);
                    fail_count++;
                end
                if (v_coord !== w.v)
                begin
                    $error("v_coord: expected %0d, got %0d", w.v, v_coord);
                    fail_count++;
                end
                if (index_error !== w.err)
                begin
                    $error("index_error: expected %0d, got %0d", w.err, index_error);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 400000)
        begin
            $display("status: fail");
            $finish;
        end
    end

endmodule
